// File: rtl/pqft_pkg.sv
// Shared types, constants and codes of the stable priority queue.
package pqft_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH   = 64;
    localparam int SEVERITY_BITS = 16;
    localparam int TAG_BITS      = 16;
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_BITS = ((SEVERITY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((TAG_BITS + SEVERITY_BITS + 7) / 8) * 8;
    localparam int STATUS_BITS  = 2;

    // Request kinds on the input tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    // Result status codes on the output tuser
    localparam logic [STATUS_BITS-1:0] ST_SERVED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd2;

    // Cell operations broadcast along the chain
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    // One stored entry
    typedef struct packed {
        logic                     valid;
        logic [SEVERITY_BITS-1:0] severity;
        logic [TAG_BITS-1:0]      tag;
    } entry_t;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic [1:0]               op;
        logic [SEVERITY_BITS-1:0] severity;
        logic [TAG_BITS-1:0]      tag;
    } cell_ctrl_t;

endpackage

// File: rtl/pqft_cell.sv
// One slot of the sorted shift chain: holds an entry, takes new data or a neighbor's.
module pqft_cell
    import pqft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl_i,
    input  entry_t     prev_entry_i,   // neighbor toward the head
    input  logic       prev_before_i,  // new entry lands at or above the neighbor
    input  entry_t     next_entry_i,   // neighbor toward the tail
    output entry_t     entry_o,
    output logic       before_o        // new entry lands at or above this cell
);

    logic                     valid_reg, valid_next;
    logic [SEVERITY_BITS-1:0] sev_reg, sev_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;

    // New entry goes ahead of this one only if strictly more severe, keeping arrival order
    assign before_o = !valid_reg || (ctrl_i.severity > sev_reg);

    // Pick the next content: hold, shift toward tail on insert, shift toward head on pop
    always_comb begin
        valid_next = valid_reg;
        sev_next   = sev_reg;
        tag_next   = tag_reg;
        case (ctrl_i.op)
            OP_INSERT: begin
                if (prev_before_i) begin
                    valid_next = prev_entry_i.valid;
                    sev_next   = prev_entry_i.severity;
                    tag_next   = prev_entry_i.tag;
                end else if (before_o) begin
                    valid_next = 1'b1;
                    sev_next   = ctrl_i.severity;
                    tag_next   = ctrl_i.tag;
                end
            end
            OP_POP: begin
                valid_next = next_entry_i.valid;
                sev_next   = next_entry_i.severity;
                tag_next   = next_entry_i.tag;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        sev_reg <= sev_next;
        tag_reg <= tag_next;
    end

    assign entry_o = '{valid: valid_reg, severity: sev_reg, tag: tag_reg};

endmodule

// File: rtl/priority_queue_fifo_tiebreak_core.sv
// Top level of the stable max-priority queue built as a sorted chain of cells.
//
// Usage: each input beat is a request. s_tuser selects insert (0) or serve (1);
// s_tdata carries severity and tag of an insert. Entries sit in a chain of
// QUEUE_DEPTH cells kept sorted by severity, highest at the head; equal
// severities stay in arrival order, so the earliest of them is served first.
// An insert takes effect in the cycle it is accepted and yields no beat.
// A serve pops the head cell and returns its tag and severity on the m_ channel
// in the cycle after acceptance, with status served. A serve of an empty
// queue returns status empty, an insert into a full queue is dropped and
// returns status full, both with zero tag and severity.
// Throughput: one request per cycle while no result beat waits; the rate is set by
// the compare-and-shift step that every cell makes in parallel.
// While a result beat waits on m_tready low, s_tready drops and the chain
// holds. Reset (aresetn low, synchronous) empties the queue and the output.
module priority_queue_fifo_tiebreak_core
    import pqft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // severity, tag
    input  logic                    s_tuser,   // mode
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // served_tag, served_severity
    output logic [STATUS_BITS-1:0]  m_tuser    // status
);

    localparam entry_t EMPTY_ENTRY = '0;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_BITS-1:0]  m_tuser_reg, m_tuser_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;
    entry_t     cell_q [QUEUE_DEPTH];
    logic       lands_above [QUEUE_DEPTH];

    // Accept while the output slot is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the request into a chain operation
    always_comb begin
        ctrl.severity = s_tdata[SEVERITY_BITS-1:0];
        ctrl.tag      = s_tdata[SEVERITY_BITS +: TAG_BITS];
        ctrl.op       = OP_HOLD;
        if (accept) begin
            if (s_tuser == MODE_INSERT && !is_full) begin
                ctrl.op = OP_INSERT;
            end else if (s_tuser == MODE_SERVE && !is_empty) begin
                ctrl.op = OP_POP;
            end
        end
    end

    // Chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        entry_t prev_entry;
        entry_t next_entry;
        logic   prev_before;

        if (i == 0) begin : g_head
            assign prev_entry  = EMPTY_ENTRY;
            assign prev_before = 1'b0;
        end else begin : g_body
            assign prev_entry  = cell_q[i-1];
            assign prev_before = lands_above[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = EMPTY_ENTRY;
        end else begin : g_link
            assign next_entry = cell_q[i+1];
        end

        pqft_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl_i        (ctrl),
            .prev_entry_i  (prev_entry),
            .prev_before_i (prev_before),
            .next_entry_i  (next_entry),
            .entry_o       (cell_q[i]),
            .before_o      (lands_above[i])
        );
    end

    // Track occupancy
    always_comb begin
        count_next = count_reg;
        case (ctrl.op)
            OP_INSERT: count_next = count_reg + CNT_BITS'(1);
            OP_POP:    count_next = count_reg - CNT_BITS'(1);
            default:   count_next = count_reg;
        endcase
    end

    // Build the result beat
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept) begin
            if (s_tuser == MODE_SERVE) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                if (is_empty) begin
                    m_tuser_next = ST_EMPTY;
                end else begin
                    m_tdata_next[TAG_BITS-1:0]            = cell_q[0].tag;
                    m_tdata_next[TAG_BITS +: SEVERITY_BITS] = cell_q[0].severity;
                    m_tuser_next                          = ST_SERVED;
                end
            end else if (is_full) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tuser_next  = ST_FULL;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            count_reg    <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Head cell occupied exactly when the count is nonzero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == !cell_q[0].valid)
        else $error("occupancy count disagrees with head cell");

    // Count never exceeds the chain length
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("occupancy count overflow");

    // An insert into a full queue reports full on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == MODE_INSERT && is_full) |=>
            (m_tvalid && m_tuser == ST_FULL && $stable(count_reg)))
        else $error("full insert not reported");

    // Neighboring occupied cells stay in severity order
    for (genvar k = 0; k + 1 < QUEUE_DEPTH; k++) begin : g_order_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            cell_q[k+1].valid |-> (cell_q[k].valid &&
                cell_q[k].severity >= cell_q[k+1].severity))
            else $error("chain out of order");
    end

endmodule
